// ----- rtl/ara_pkg.sv -----
// ----------------------------------------------------------------------------
// Atlas rectangle allocator package
// Shared types, sizes and codes for the allocator and its region scanner.
// ----------------------------------------------------------------------------
package ara_pkg;

  localparam int MaxRegions = 64;
  localparam int MaxPlaced  = 32;
  localparam int RegAw      = $clog2(MaxRegions);
  localparam int PlcAw      = $clog2(MaxPlaced);
  localparam int RegCw      = $clog2(MaxRegions + 1);
  localparam int PlcCw      = $clog2(MaxPlaced + 1);
  localparam logic [12:0] CanvasReset = 13'd4096;

  localparam logic [2:0] ST_PLACED    = 3'd0;
  localparam logic [2:0] ST_ALREADY   = 3'd1;
  localparam logic [2:0] ST_NO_FIT    = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic [0:0] ADDR_CANVAS_WIDTH  = 1'b0;
  localparam logic [0:0] ADDR_CANVAS_HEIGHT = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] texture_id;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] pos_x;
    logic [12:0] pos_y;
    logic [12:0] size_w;
    logic [12:0] size_h;
  } rsp_t;

  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [12:0] w;
    logic [12:0] h;
    logic        used;
  } region_t;

  typedef struct packed {
    logic [31:0] id;
    logic [12:0] x;
    logic [12:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } place_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ID_SCAN, S_ID_LAST, S_REG_SCAN, S_REG_LAST,
    S_BEST_RD, S_BEST_WAIT, S_COMMIT, S_WR_RIGHT, S_WR_TOP, S_OUT
  } state_t;

endpackage

// ----- rtl/atlas_rect_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Atlas rectangle allocator
// Guillotine packing of rectangles into a rectangular canvas, best area fit.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (valid/ready) and each gives one
// response on the rsp channel unless a canvas write aborts it. Place mode
// finds an id or else takes the smallest free region that fits and splits
// it; lookup mode returns a stored placement. Canvas size is set through the
// APB port; a write clears both tables.
// One request is worked at a time. The placement table is read one entry a
// cycle, then, when a place request needs a region, the region table one
// entry a cycle, both from synchronous-read memories.
// After reset, and after every canvas write, a clearing state writes the
// initial free region; requests wait during it.
// A finished response sits in an output register; if the receiver stalls,
// the block holds it and takes no new request until it is transferred.
// ----------------------------------------------------------------------------
module atlas_rect_allocator_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ara_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ara_pkg::rsp_t   rsp,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int RegAw = ara_pkg::RegAw;
  localparam int PlcAw = ara_pkg::PlcAw;
  localparam int RegCw = ara_pkg::RegCw;
  localparam int PlcCw = ara_pkg::PlcCw;

  ara_pkg::state_t state, state_next;

  logic [12:0] canvas_width, canvas_height;
  logic        cfg_wr;
  ara_pkg::req_t cur;
  logic [RegCw-1:0] region_count;
  logic [PlcCw-1:0] placement_count;
  logic [RegCw-1:0] idx;
  ara_pkg::place_t  hit_place;
  logic             hit;

  // Memories
  ara_pkg::region_t region_mem [ara_pkg::MaxRegions];
  ara_pkg::place_t  place_mem  [ara_pkg::MaxPlaced];
  ara_pkg::region_t reg_rd;
  ara_pkg::place_t  plc_rd;
  logic             reg_we, plc_we;
  logic [RegAw-1:0] reg_waddr, reg_raddr;
  ara_pkg::region_t reg_wdata;
  logic [PlcAw-1:0] plc_raddr;
  ara_pkg::place_t  plc_wdata;
  logic             rd_valid;
  logic [RegAw-1:0] rd_slot;

  always_ff @(posedge clk) begin
    if (reg_we) region_mem[reg_waddr] <= reg_wdata;
    reg_rd <= region_mem[reg_raddr];
  end

  always_ff @(posedge clk) begin
    if (plc_we) place_mem[placement_count[PlcAw-1:0]] <= plc_wdata;
    plc_rd <= place_mem[plc_raddr];
  end

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ara_pkg::ADDR_CANVAS_HEIGHT) ? {19'd0, canvas_height}
                                                           : {19'd0, canvas_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= ara_pkg::CanvasReset;
      canvas_height <= ara_pkg::CanvasReset;
    end else if (cfg_wr) begin
      if (paddr[2] == ara_pkg::ADDR_CANVAS_WIDTH) canvas_width <= pwdata[12:0];
      else canvas_height <= pwdata[12:0];
    end
  end

  // Best-fit tracker
  logic fit_found;
  logic [RegAw-1:0] fit_best;

  ara_fit_scan u_fit (
    .clk         (clk),
    .start       (state == ara_pkg::S_IDLE),
    .valid       (rd_valid),
    .slot        (rd_slot),
    .region      (reg_rd),
    .rect_width  (cur.rect_width),
    .rect_height (cur.rect_height),
    .found       (fit_found),
    .best        (fit_best)
  );

  // Held best region and its split
  ara_pkg::region_t br;
  logic [13:0] rx_sum, ty_sum;
  logic add_right, add_top;
  logic [RegCw:0] need_total;
  assign rx_sum    = {1'b0, br.x} + {1'b0, cur.rect_width};
  assign ty_sum    = {1'b0, br.y} + {1'b0, cur.rect_height};
  assign add_right = rx_sum < {1'b0, canvas_width};
  assign add_top   = ty_sum < {1'b0, canvas_height};
  assign need_total = {1'b0, region_count} + (RegCw+1)'(add_right) + (RegCw+1)'(add_top);

  ara_pkg::rsp_t rsp_next;

  // Set once the placement is committed, so the region-full check ignores
  // the counts that the commit itself advanced.
  logic placed_flag;
  always_ff @(posedge clk) begin
    if (state == ara_pkg::S_IDLE) placed_flag <= 1'b0;
    else if (plc_we) placed_flag <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ara_pkg::S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= cfg_wr ? ara_pkg::S_CLEAR : state_next;
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      else if (state == ara_pkg::S_OUT && !cfg_wr) rsp_valid <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= RegCw'(1);
      placement_count <= '0;
    end else if (state == ara_pkg::S_CLEAR) begin
      region_count <= RegCw'(1);
      placement_count <= '0;
    end else begin
      if (plc_we) placement_count <= placement_count + PlcCw'(1);
      if (state == ara_pkg::S_WR_RIGHT || state == ara_pkg::S_WR_TOP)
        region_count <= region_count + RegCw'(1);
    end
    if (req_valid && req_ready) cur <= req;
    if (state == ara_pkg::S_IDLE) begin
      idx <= '0;
      hit <= 1'b0;
    end else if (state == ara_pkg::S_ID_SCAN || state == ara_pkg::S_REG_SCAN) begin
      idx <= idx + RegCw'(1);
    end else if (state == ara_pkg::S_ID_LAST) begin
      idx <= '0;
    end
    // The ID-LAST step also folds in the last entry's compare.
    if (state == ara_pkg::S_ID_SCAN || state == ara_pkg::S_ID_LAST) begin
      if (idx != '0 && !hit && plc_rd.id == cur.texture_id) begin
        hit <= 1'b1;
        hit_place <= plc_rd;
      end
    end
    rd_valid <= state == ara_pkg::S_REG_SCAN;
    rd_slot  <= idx[RegAw-1:0];
    if (state == ara_pkg::S_BEST_WAIT) br <= reg_rd;
    if (state == ara_pkg::S_OUT) rsp <= rsp_next;
  end

  // Next state and memory controls
  always_comb begin
    state_next = state;
    reg_we = 1'b0;
    reg_waddr = '0;
    reg_wdata = '0;
    reg_raddr = idx[RegAw-1:0];
    plc_raddr = idx[PlcAw-1:0];
    plc_we = 1'b0;
    plc_wdata = '0;
    req_ready = 1'b0;
    rsp_next = '0;
    case (state)
      ara_pkg::S_CLEAR: begin
        reg_we = 1'b1;
        reg_wdata = '{x: 13'd0, y: 13'd0, w: canvas_width, h: canvas_height, used: 1'b0};
        state_next = ara_pkg::S_IDLE;
      end
      ara_pkg::S_IDLE: begin
        req_ready = !rsp_valid;
        if (req_valid && !rsp_valid) begin
          state_next = (placement_count == '0) ? ara_pkg::S_ID_LAST : ara_pkg::S_ID_SCAN;
        end
      end
      ara_pkg::S_ID_SCAN: begin
        // idx addresses entry idx; data of entry idx-1 is compared.
        if (idx + RegCw'(1) >= RegCw'(placement_count)) state_next = ara_pkg::S_ID_LAST;
      end
      ara_pkg::S_ID_LAST: begin
        if (hit || (placement_count != '0 && plc_rd.id == cur.texture_id))
          state_next = ara_pkg::S_OUT;
        else if (cur.mode) state_next = ara_pkg::S_OUT;
        else if (placement_count == PlcCw'(ara_pkg::MaxPlaced)) state_next = ara_pkg::S_OUT;
        else state_next = ara_pkg::S_REG_SCAN;
      end
      ara_pkg::S_REG_SCAN: begin
        if (idx + RegCw'(1) >= region_count) state_next = ara_pkg::S_REG_LAST;
      end
      ara_pkg::S_REG_LAST: begin
        state_next = ara_pkg::S_BEST_RD;
      end
      ara_pkg::S_BEST_RD: begin
        reg_raddr = fit_best;
        state_next = fit_found ? ara_pkg::S_BEST_WAIT : ara_pkg::S_OUT;
      end
      ara_pkg::S_BEST_WAIT: begin
        state_next = ara_pkg::S_COMMIT;
      end
      ara_pkg::S_COMMIT: begin
        if (need_total > (RegCw+1)'(ara_pkg::MaxRegions)) begin
          state_next = ara_pkg::S_OUT;
        end else begin
          reg_we = 1'b1;
          reg_waddr = fit_best;
          reg_wdata = '{x: br.x, y: br.y, w: cur.rect_width, h: cur.rect_height, used: 1'b1};
          plc_we = 1'b1;
          plc_wdata = '{id: cur.texture_id, x: br.x, y: br.y,
                        w: cur.rect_width, h: cur.rect_height};
          state_next = add_right ? ara_pkg::S_WR_RIGHT
                     : add_top ? ara_pkg::S_WR_TOP : ara_pkg::S_OUT;
        end
      end
      ara_pkg::S_WR_RIGHT: begin
        reg_we = 1'b1;
        reg_waddr = region_count[RegAw-1:0];
        reg_wdata = '{x: rx_sum[12:0], y: br.y, w: br.w - cur.rect_width,
                      h: cur.rect_height, used: 1'b0};
        state_next = add_top ? ara_pkg::S_WR_TOP : ara_pkg::S_OUT;
      end
      ara_pkg::S_WR_TOP: begin
        reg_we = 1'b1;
        reg_waddr = region_count[RegAw-1:0];
        reg_wdata = '{x: br.x, y: ty_sum[12:0], w: br.w,
                      h: br.h - cur.rect_height, used: 1'b0};
        state_next = ara_pkg::S_OUT;
      end
      ara_pkg::S_OUT: begin
        state_next = ara_pkg::S_IDLE;
      end
      default: state_next = ara_pkg::S_CLEAR;
    endcase

    // Response selection, valid in S_OUT.
    if (hit) begin
      rsp_next = '{status: cur.mode ? ara_pkg::ST_FOUND : ara_pkg::ST_ALREADY,
                   pos_x: hit_place.x, pos_y: hit_place.y,
                   size_w: hit_place.w, size_h: hit_place.h};
    end else if (cur.mode) begin
      rsp_next.status = ara_pkg::ST_NOT_FOUND;
    end else if (placement_count == PlcCw'(ara_pkg::MaxPlaced) && !fit_found) begin
      rsp_next.status = ara_pkg::ST_FULL;
    end else if (!fit_found) begin
      rsp_next.status = ara_pkg::ST_NO_FIT;
    end else if (need_total > (RegCw+1)'(ara_pkg::MaxRegions) && !placed_flag) begin
      rsp_next.status = ara_pkg::ST_FULL;
    end else begin
      rsp_next = '{status: ara_pkg::ST_PLACED, pos_x: br.x, pos_y: br.y,
                   size_w: cur.rect_width, size_h: cur.rect_height};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    region_count <= RegCw'(ara_pkg::MaxRegions))
    else $error("region count beyond table");
  a_plc_bound: assert property (@(posedge clk) disable iff (rst)
    placement_count <= PlcCw'(ara_pkg::MaxPlaced))
    else $error("placement count beyond table");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> state == ara_pkg::S_IDLE && !rsp_valid)
    else $error("request accepted while busy");
  a_commit_fit: assert property (@(posedge clk) disable iff (rst)
    plc_we |-> fit_found)
    else $error("placement without a fitting region");

endmodule

// ----- rtl/ara_fit_scan.sv -----
// ----------------------------------------------------------------------------
// Allocator best-fit tracker
// Takes one region per cycle while valid is high and keeps the smallest-area
// free region that holds the requested rectangle, the earlier one on a tie.
// ----------------------------------------------------------------------------
module ara_fit_scan (
  input  logic                   clk,
  input  logic                   start,
  input  logic                   valid,
  input  logic [ara_pkg::RegAw-1:0] slot,
  input  ara_pkg::region_t       region,
  input  logic [12:0]            rect_width,
  input  logic [12:0]            rect_height,
  output logic                   found,
  output logic [ara_pkg::RegAw-1:0] best
);

  logic [25:0] best_area;
  logic [25:0] area;
  logic        fits;

  assign area = region.w * region.h;
  assign fits = !region.used && region.w >= rect_width && region.h >= rect_height;

  always_ff @(posedge clk) begin
    if (start) begin
      found <= 1'b0;
    end else if (valid && fits && (!found || area < best_area)) begin
      found     <= 1'b1;
      best      <= slot;
      best_area <= area;
    end
  end

endmodule

// ----- tb/sv/atlas_rect_allocator_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Atlas rectangle allocator testbench
// Drives place and lookup requests through the request channel, with random
// idling on both sides. A behavioral packer predicts every response, and a
// monitor compares each response with the oldest prediction, field by field.
// The canvas size is changed over APB between phases, the extremes among them.
// ----------------------------------------------------------------------------
module atlas_rect_allocator_top_test;

  localparam int LimitCycles = 2000000;

  logic            clk;
  logic            rst;
  logic            req_valid;
  logic            req_ready;
  ara_pkg::req_t   req;
  logic            rsp_valid;
  logic            rsp_ready;
  ara_pkg::rsp_t   rsp;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [2:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  atlas_rect_allocator_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Packer state kept by the testbench.
  logic [12:0]       canvas_w, canvas_h;
  ara_pkg::region_t  free_list [ara_pkg::MaxRegions];
  int                free_cnt;
  ara_pkg::place_t   placed [ara_pkg::MaxPlaced];
  int                placed_cnt;

  ara_pkg::req_t pending_reqs[$];
  ara_pkg::rsp_t expected_rsps[$];
  int   error_count;
  int   cycle_count;
  bit   quiet_phase;
  int   rsp_hold_long;
  int   req_gap, rsp_gap;
  logic [31:0] id_pool[$];

  task automatic reset_packer();
    free_list[0] = '{x: 13'd0, y: 13'd0, w: canvas_w, h: canvas_h, used: 1'b0};
    free_cnt = 1;
    placed_cnt = 0;
  endtask

  function automatic ara_pkg::rsp_t pack_rect(ara_pkg::req_t r);
    ara_pkg::rsp_t    o;
    int               best, need;
    longint           area, best_area;
    bit               found, add_right, add_top;
    ara_pkg::region_t rg, right, top;
    o = '0;
    for (int i = 0; i < placed_cnt; i++) begin
      if (placed[i].id == r.texture_id) begin
        o.status = r.mode ? ara_pkg::ST_FOUND : ara_pkg::ST_ALREADY;
        o.pos_x = placed[i].x; o.pos_y = placed[i].y;
        o.size_w = placed[i].w; o.size_h = placed[i].h;
        return o;
      end
    end
    if (r.mode) begin
      o.status = ara_pkg::ST_NOT_FOUND;
      return o;
    end
    if (placed_cnt >= ara_pkg::MaxPlaced) begin
      o.status = ara_pkg::ST_FULL;
      return o;
    end
    found = 0; best = 0; best_area = 0;
    for (int i = 0; i < free_cnt; i++) begin
      rg = free_list[i];
      if (rg.used || rg.w < r.rect_width || rg.h < r.rect_height) continue;
      area = longint'(rg.w) * longint'(rg.h);
      if (!found || area < best_area) begin
        found = 1; best = i; best_area = area;
      end
    end
    if (!found) begin
      o.status = ara_pkg::ST_NO_FIT;
      return o;
    end
    rg = free_list[best];
    add_right = (32'(rg.x) + 32'(r.rect_width)) < 32'(canvas_w);
    add_top = (32'(rg.y) + 32'(r.rect_height)) < 32'(canvas_h);
    need = int'(add_right) + int'(add_top);
    if (free_cnt + need > ara_pkg::MaxRegions) begin
      o.status = ara_pkg::ST_FULL;
      return o;
    end
    right = '{x: rg.x + r.rect_width, y: rg.y, w: rg.w - r.rect_width,
              h: r.rect_height, used: 1'b0};
    top = '{x: rg.x, y: rg.y + r.rect_height, w: rg.w,
            h: rg.h - r.rect_height, used: 1'b0};
    free_list[best].w = r.rect_width;
    free_list[best].h = r.rect_height;
    free_list[best].used = 1'b1;
    placed[placed_cnt] = '{id: r.texture_id, x: rg.x, y: rg.y,
                           w: r.rect_width, h: r.rect_height};
    placed_cnt++;
    if (add_right) free_list[free_cnt++] = right;
    if (add_top) free_list[free_cnt++] = top;
    o.status = ara_pkg::ST_PLACED;
    o.pos_x = rg.x; o.pos_y = rg.y; o.size_w = r.rect_width; o.size_h = r.rect_height;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("status: fail");
      $finish;
    end
  end

  // Driver: offers the oldest pending item, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 0;
      req_gap <= 0;
    end else if (req_valid && !req_ready) begin
      // hold the offered item
    end else begin
      if (req_valid) void'(pending_reqs.pop_front());
      if (req_gap > 0) begin
        req_gap <= req_gap - 1;
        req_valid <= 0;
      end else if (pending_reqs.size() > 0) begin
        if (!quiet_phase && $urandom_range(0, 9) == 0) begin
          req_gap <= $urandom_range(1, 16);
          req_valid <= 0;
        end else begin
          req_valid <= 1;
          req <= pending_reqs[0];
        end
      end else begin
        req_valid <= 0;
      end
    end
  end

  // Prediction on each accepted request.
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) expected_rsps = {expected_rsps, pack_rect(req)};
  end

  // Receiver stalls and checks responses.
  always @(posedge clk) begin
    ara_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 0;
      rsp_gap <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", 32'(rsp.status), 32'd0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.pos_x !== want.pos_x)
            report_mismatch("pos_x", 32'(rsp.pos_x), 32'(want.pos_x));
          if (rsp.pos_y !== want.pos_y)
            report_mismatch("pos_y", 32'(rsp.pos_y), 32'(want.pos_y));
          if (rsp.size_w !== want.size_w)
            report_mismatch("size_w", 32'(rsp.size_w), 32'(want.size_w));
          if (rsp.size_h !== want.size_h)
            report_mismatch("size_h", 32'(rsp.size_h), 32'(want.size_h));
        end
      end
      if (rsp_hold_long > 0) begin
        rsp_hold_long <= rsp_hold_long - 1;
        rsp_ready <= 0;
      end else if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_ready <= 0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        rsp_gap <= $urandom_range(1, 16);
        rsp_ready <= 0;
      end else begin
        rsp_ready <= 1;
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == 3'(ara_pkg::ADDR_CANVAS_WIDTH) * 4) canvas_w = data[12:0];
    else canvas_h = data[12:0];
    reset_packer();
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_id();
    if (id_pool.size() > 0 && $urandom_range(0, 3) == 0)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    return $urandom();
  endfunction

  task automatic add_req(logic mode, logic [31:0] id, logic [12:0] w, logic [12:0] h);
    ara_pkg::req_t r;
    r.mode = mode; r.texture_id = id; r.rect_width = w; r.rect_height = h;
    pending_reqs = {pending_reqs, r};
    if (!mode) id_pool = {id_pool, id};
  endtask

  // Random requests sized to the canvas so that placements mostly succeed.
  task automatic add_random(int n, int maxdim);
    logic [12:0] w, h;
    for (int i = 0; i < n; i++) begin
      w = (i % 37 == 0) ? 13'($urandom()) : 13'($urandom_range(0, maxdim));
      h = (i % 41 == 0) ? 13'($urandom()) : 13'($urandom_range(0, maxdim));
      add_req($urandom_range(0, 3) == 0, pick_id(), w, h);
    end
  endtask

  initial begin
    rst = 1;
    req_valid = 0; req = '0; rsp_ready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    error_count = 0; cycle_count = 0; quiet_phase = 0; rsp_hold_long = 0;
    canvas_w = ara_pkg::CanvasReset; canvas_h = ara_pkg::CanvasReset;
    reset_packer();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part on the reset canvas.
    add_req(1, 32'h0, 0, 0);                       // lookup before any placement
    add_req(0, 32'hFFFF_FFFF, 13'd4096, 13'd4096); // whole canvas
    add_req(0, 32'h1, 1, 1);                       // no fit
    add_req(0, 32'hFFFF_FFFF, 5, 5);               // already placed
    add_req(1, 32'hFFFF_FFFF, 0, 0);               // found
    add_req(1, 32'h1, 13'h1FFF, 13'h1FFF);         // not found
    wait_drained();
    apb_write(3'd0, 32'hFFFF_E000 | 32'd100);
    add_req(0, 32'h10, 0, 0);                      // zero sized
    add_req(0, 32'h11, 100, 0);
    add_req(0, 32'h12, 13'h1FFF, 1);
    for (int i = 0; i < 32; i++) add_req(0, 32'h100 + i, 1, 1); // placement table full
    add_req(1, 32'h11, 0, 0);
    wait_drained();
    apb_write(3'd4, 32'd1);
    add_req(0, 32'h20, 1, 1);
    add_req(0, 32'h21, 0, 0);
    wait_drained();
    // Many thin slices to exhaust the region table.
    apb_write(3'd4, 32'd4096);
    apb_write(3'd0, 32'd4096);
    for (int i = 0; i < 34; i++) add_req(0, 32'h200 + i, 0, 0);
    wait_drained();

    // Random phases over several canvas sizes.
    for (int ph = 0; ph < 8; ph++) begin
      int cw, ch;
      cw = (ph == 0) ? 1 : (ph == 1) ? 4096 : $urandom_range(1, 4096);
      ch = (ph == 2) ? 1 : (ph == 1) ? 4096 : $urandom_range(1, 4096);
      apb_write(3'd0, 32'(cw));
      apb_write(3'd4, 32'(ch));
      id_pool.delete();
      if (ph == 3) rsp_hold_long = 400;
      if (ph == 7) quiet_phase = 1;
      add_random(100, (cw > ch ? cw : ch) / 4 + 1);
      wait_drained();
    end

    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ara_pkg.sv
rtl/ara_fit_scan.sv
rtl/atlas_rect_allocator_top.sv
tb/sv/atlas_rect_allocator_top_test.sv
